// File: hw/rtl/cddn_pkg.sv
// Shared types, constants and calendar tables for the date / day number converter.
package cddn_pkg;

  // Opcodes.
  localparam logic OP_TO_NUMBER = 1'b0;
  localparam logic OP_TO_DATE   = 1'b1;

  // Day number landmarks. A day number of 1 is 0001-01-01.
  localparam logic [19:0] DN_END_1899   = 20'd693595;  // 1899-12-31
  localparam logic [19:0] DN_FIRST_1900 = 20'd693596;  // 1900-01-01
  localparam logic [19:0] DN_END_2027   = 20'd740346;  // 2027-12-31
  // Day count of all years before year 1900 + yo, minus its closed-form correction.
  localparam logic [19:0] DN_YEAR_BASE  = 20'd693594;

  localparam logic [8:0]  DAYS_IN_YEAR  = 9'd365;
  localparam logic [10:0] DAYS_IN_CYCLE = 11'd1461;
  // Reciprocal of the four-year cycle length, exact for offsets below 2^16.
  localparam logic [15:0] CYCLE_RECIP   = 16'd45934;
  localparam int          CYCLE_SHIFT   = 26;
  localparam int          CYCLE_Q_W     = 5;

  // Month search on the shifted day of year: month = (t * 100 + 3007) / 3057.
  localparam logic [15:0] MONTH_SCALE   = 16'd100;
  localparam logic [15:0] MONTH_OFFSET  = 16'd3007;
  localparam logic [15:0] MONTH_STEP    = 16'd3057;
  localparam int          MONTHS        = 12;

  typedef struct packed {
    logic        opcode;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [6:0]  in_year_offset;
    logic [19:0] in_day_number;
  } in_item_t;

  typedef struct packed {
    logic [19:0] out_day_number;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [6:0]  out_year_offset;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic        leap_year;
    logic [4:0]  month_length;
    logic        valid_res;
  } out_item_t;

  // Fields that both paths carry to the end of the pipeline.
  typedef struct packed {
    logic        op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [6:0]  year_off;
    logic [19:0] day_num;
    logic        leap;
    logic [4:0]  mlen;
    logic        date_ok;
    logic [8:0]  doy;
  } carry_t;

  typedef struct packed {
    carry_t      c;
    logic [15:0] yr_base;
    logic        in_range;
    logic        first_year;
    logic [8:0]  r_lo;
    logic [15:0] s;
  } front_t;

  typedef struct packed {
    carry_t      c;
    logic [19:0] dn;
    logic        in_range;
    logic        first_year;
    logic [8:0]  r_lo;
    logic [CYCLE_Q_W-1:0] q;
    logic [10:0] rem;
    logic [5:0]  wsum;
  } year_t;

  typedef struct packed {
    carry_t      c;
    logic [19:0] dn;
    logic        in_range;
    logic [8:0]  t;
    logic [8:0]  doy1;
    logic [6:0]  yo1;
    logic        lp1;
    logic [3:0]  mo;
    logic [2:0]  wd;
  } month_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd61;
      4'd4:    v = 9'd92;
      4'd5:    v = 9'd122;
      4'd6:    v = 9'd153;
      4'd7:    v = 9'd183;
      4'd8:    v = 9'd214;
      4'd9:    v = 9'd245;
      4'd10:   v = 9'd275;
      4'd11:   v = 9'd306;
      4'd12:   v = 9'd336;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
      4'd2:    v = leap ? 5'd29 : 5'd28;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  // Sum of the octal digits; congruent to the argument modulo 7.
  function automatic logic [5:0] octal_digit_sum(input logic [19:0] x);
    logic [20:0] xe;
    logic [5:0]  s;
    xe = {1'b0, x};
    s  = '0;
    for (int i = 0; i < 7; i++) begin
      s = s + 6'(xe[3*i +: 3]);
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/cddn_front.sv
// First pipeline stage: date decoding and day number range split.
module cddn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  cddn_pkg::in_item_t  item_i,
  output logic                valid_o,
  input  logic                ready_i,
  output cddn_pkg::front_t    stage_o
);

  cddn_pkg::front_t stage_d, stage_q;
  logic             valid_q;
  logic             en;
  logic             leap;
  logic [4:0]       mlen;
  logic [1:0]       adj;
  logic [7:0]       yo_up;
  logic [19:0]      r_full;

  always_comb begin
    leap  = (item_i.in_year_offset[1:0] == 2'b00) && (item_i.in_year_offset != 7'd0);
    mlen  = cddn_pkg::month_length(item_i.in_month, leap);
    adj   = (item_i.in_month > 4'd2) ? (leap ? 2'd1 : 2'd2) : 2'd0;
    yo_up = {1'b0, item_i.in_year_offset} + 8'd3;

    stage_d.c.op       = item_i.opcode;
    stage_d.c.day      = item_i.in_day;
    stage_d.c.month    = item_i.in_month;
    stage_d.c.year_off = item_i.in_year_offset;
    stage_d.c.day_num  = item_i.in_day_number;
    stage_d.c.leap     = leap;
    stage_d.c.mlen     = mlen;
    stage_d.c.date_ok  = (item_i.in_day != 5'd0) && (mlen != 5'd0) &&
                         (item_i.in_day <= mlen);
    stage_d.c.doy      = cddn_pkg::days_before_month(item_i.in_month) +
                         9'(item_i.in_day) - 9'(adj);

    // Days from 1900-01-01 to the year's start plus one, before the common base.
    stage_d.yr_base    = 16'(item_i.in_year_offset) * 16'(cddn_pkg::DAYS_IN_YEAR) +
                         16'(yo_up[7:2]) + 16'(item_i.in_year_offset == 7'd0);

    stage_d.in_range   = (item_i.in_day_number > cddn_pkg::DN_END_1899) &&
                         (item_i.in_day_number <= cddn_pkg::DN_END_2027);
    r_full             = item_i.in_day_number - cddn_pkg::DN_FIRST_1900;
    stage_d.first_year = r_full[15:0] < 16'(cddn_pkg::DAYS_IN_YEAR);
    stage_d.r_lo       = r_full[8:0];
    stage_d.s          = r_full[15:0] - 16'(cddn_pkg::DAYS_IN_YEAR);
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign stage_o = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      stage_q <= stage_d;
    end
  end

endmodule

// File: hw/rtl/cddn_year.sv
// Day number assembly, four-year cycle split and weekday digit sum (two stages).
module cddn_year (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  cddn_pkg::front_t   stage_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cddn_pkg::year_t    stage_o
);

  typedef struct packed {
    cddn_pkg::carry_t c;
    logic [19:0] dn;
    logic        in_range;
    logic        first_year;
    logic [8:0]  r_lo;
    logic [15:0] s;
    logic [cddn_pkg::CYCLE_Q_W-1:0] q;
    logic [19:0] x;
  } split_t;

  split_t           b_d, b_q;
  cddn_pkg::year_t  c_d, c_q;
  logic             vb_q, vc_q;
  logic             en_b, en_c;
  logic [31:0]      prod;
  logic [15:0]      rem_full;

  always_comb begin
    prod          = 32'(stage_i.s) * 32'(cddn_pkg::CYCLE_RECIP);
    b_d.c          = stage_i.c;
    b_d.dn         = cddn_pkg::DN_YEAR_BASE + 20'(stage_i.yr_base) + 20'(stage_i.c.doy);
    b_d.in_range   = stage_i.in_range;
    b_d.first_year = stage_i.first_year;
    b_d.r_lo       = stage_i.r_lo;
    b_d.s          = stage_i.s;
    b_d.q          = prod[cddn_pkg::CYCLE_SHIFT +: cddn_pkg::CYCLE_Q_W];
    b_d.x          = (stage_i.c.op == cddn_pkg::OP_TO_DATE) ?
                     (stage_i.c.day_num - 20'd1) : (b_d.dn - 20'd1);
  end

  always_comb begin
    rem_full       = b_q.s - 16'(b_q.q) * 16'(cddn_pkg::DAYS_IN_CYCLE);
    c_d.c          = b_q.c;
    c_d.dn         = b_q.dn;
    c_d.in_range   = b_q.in_range;
    c_d.first_year = b_q.first_year;
    c_d.r_lo       = b_q.r_lo;
    c_d.q          = b_q.q;
    c_d.rem        = rem_full[10:0];
    c_d.wsum       = cddn_pkg::octal_digit_sum(b_q.x);
  end

  assign en_c    = !vc_q || ready_i;
  assign en_b    = !vb_q || en_c;
  assign ready_o = en_b;
  assign valid_o = vc_q;
  assign stage_o = c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_b) begin
        vb_q <= valid_i;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && valid_i) begin
      b_q <= b_d;
    end
    if (en_c && vb_q) begin
      c_q <= c_d;
    end
  end

endmodule

// File: hw/rtl/cddn_month.sv
// Year and day of year recovery, then month search and weekday fold (two stages).
module cddn_month (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  cddn_pkg::year_t    stage_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cddn_pkg::month_t   stage_o
);

  typedef struct packed {
    cddn_pkg::carry_t c;
    logic [19:0] dn;
    logic        in_range;
    logic [8:0]  t;
    logic [8:0]  doy1;
    logic [6:0]  yo1;
    logic        lp1;
    logic [3:0]  w2;
  } dayof_t;

  dayof_t           d_d, d_q;
  cddn_pkg::month_t e_d, e_q;
  logic             vd_q, ve_q;
  logic             en_d, en_e;
  logic [1:0]       yr_in;
  logic [10:0]      yr_days;
  logic [10:0]      rem_doy;
  logic [8:0]       doy1;
  logic             lp1;
  logic [15:0]      xm;
  logic [3:0]       mo;
  logic [2:0]       w3;

  // Stage D: year inside the four-year cycle, then the shifted day of year.
  always_comb begin
    if (stage_i.rem >= 11'(3 * cddn_pkg::DAYS_IN_YEAR)) begin
      yr_in = 2'd3;
    end else if (stage_i.rem >= 11'(2 * cddn_pkg::DAYS_IN_YEAR)) begin
      yr_in = 2'd2;
    end else if (stage_i.rem >= 11'(cddn_pkg::DAYS_IN_YEAR)) begin
      yr_in = 2'd1;
    end else begin
      yr_in = 2'd0;
    end
    yr_days = 11'(yr_in) * 11'(cddn_pkg::DAYS_IN_YEAR);
    rem_doy = stage_i.rem - yr_days + 11'd1;
    doy1    = stage_i.first_year ? (stage_i.r_lo + 9'd1) : rem_doy[8:0];
    // The leap year of each cycle is its last one; 1900 itself is common.
    lp1     = !stage_i.first_year && (yr_in == 2'd3);

    d_d.c        = stage_i.c;
    d_d.dn       = stage_i.dn;
    d_d.in_range = stage_i.in_range;
    d_d.doy1     = doy1;
    d_d.lp1      = lp1;
    d_d.yo1      = stage_i.first_year ? 7'd0 : (7'({stage_i.q, yr_in}) + 7'd1);
    // Shift past February so that every month has the same formula.
    if (doy1 > 9'd59) begin
      if (!lp1) begin
        d_d.t = doy1 + 9'd2;
      end else if (doy1 > 9'd60) begin
        d_d.t = doy1 + 9'd1;
      end else begin
        d_d.t = doy1;
      end
    end else begin
      d_d.t = doy1;
    end
    d_d.w2 = {1'b0, stage_i.wsum[5:3]} + {1'b0, stage_i.wsum[2:0]};
  end

  // Stage E: month from twelve parallel threshold compares.
  always_comb begin
    xm = 16'(d_q.t) * cddn_pkg::MONTH_SCALE + cddn_pkg::MONTH_OFFSET;
    mo = 4'd0;
    for (int m = 1; m <= cddn_pkg::MONTHS; m++) begin
      if (xm >= 16'(m) * cddn_pkg::MONTH_STEP) begin
        mo = mo + 4'd1;
      end
    end
    w3 = d_q.w2[2:0] + 3'(d_q.w2[3]);

    e_d.c        = d_q.c;
    e_d.dn       = d_q.dn;
    e_d.in_range = d_q.in_range;
    e_d.t        = d_q.t;
    e_d.doy1     = d_q.doy1;
    e_d.yo1      = d_q.yo1;
    e_d.lp1      = d_q.lp1;
    e_d.mo       = mo;
    e_d.wd       = (w3 == 3'd7) ? 3'd0 : w3;
  end

  assign en_e    = !ve_q || ready_i;
  assign en_d    = !vd_q || en_e;
  assign ready_o = en_d;
  assign valid_o = ve_q;
  assign stage_o = e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (en_d) begin
        vd_q <= valid_i;
      end
      if (en_e) begin
        ve_q <= vd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d && valid_i) begin
      d_q <= d_d;
    end
    if (en_e && vd_q) begin
      e_q <= e_d;
    end
  end

endmodule

// File: hw/rtl/cddn_result.sv
// Last stage: day of month, result selection and the output register.
module cddn_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  cddn_pkg::month_t    stage_i,
  output logic                valid_o,
  input  logic                ready_i,
  output cddn_pkg::out_item_t item_o
);

  cddn_pkg::out_item_t item_d, item_q;
  logic                valid_q;
  logic                en;
  logic [8:0]          dom;

  always_comb begin
    dom    = stage_i.t - cddn_pkg::days_before_month(stage_i.mo);
    item_d = '0;
    if (stage_i.c.op == cddn_pkg::OP_TO_NUMBER) begin
      item_d.out_day         = stage_i.c.day;
      item_d.out_month       = stage_i.c.month;
      item_d.out_year_offset = stage_i.c.year_off;
      item_d.leap_year       = stage_i.c.leap;
      item_d.month_length    = stage_i.c.mlen;
      if (stage_i.c.date_ok) begin
        item_d.out_day_number = stage_i.dn;
        item_d.weekday        = stage_i.wd;
        item_d.day_of_year    = stage_i.c.doy;
        item_d.valid_res      = 1'b1;
      end
    end else begin
      item_d.out_day_number = stage_i.c.day_num;
      if (stage_i.in_range) begin
        item_d.out_day         = dom[4:0];
        item_d.out_month       = stage_i.mo;
        item_d.out_year_offset = stage_i.yo1;
        item_d.weekday         = stage_i.wd;
        item_d.day_of_year     = stage_i.doy1;
        item_d.leap_year       = stage_i.lp1;
        item_d.month_length    = cddn_pkg::month_length(stage_i.mo, stage_i.lp1);
        item_d.valid_res       = 1'b1;
      end
    end
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// File: hw/rtl/calendar_date_day_number_convert.sv
// Top level of the Gregorian date / scalar day number converter.
//
// The converter takes one item per clock cycle when the output side does not
// stall, and returns one result item for each, in order. Opcode 0 turns a date
// (day, month, year minus 1900) into a day number where 1 is 0001-01-01, and
// opcode 1 turns a day number back into a date; both report the weekday (0 is
// Monday), the day of the year, the leap flag and the month length. Invalid
// dates give day number 0 with valid_res low, and day numbers outside the years
// 1900 to 2027 echo the day number with every other field and valid_res at 0.
// The six register stages are: date decode and range split, day number sum and
// the reciprocal multiply that finds the four-year cycle, cycle remainder and
// weekday digit sum, year and day of year, month compare, and the output
// register. Each stage holds its own valid bit and moves whenever the stage after
// it is free, so bubbles close up under stall and in_stall_o rises only when
// every stage holds an item that cannot advance.

module calendar_date_day_number_convert (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cddn_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cddn_pkg::out_item_t out_item_o
);

  cddn_pkg::front_t front_stage;
  cddn_pkg::year_t  year_stage;
  cddn_pkg::month_t month_stage;

  logic front_ready, front_valid;
  logic year_ready, year_valid;
  logic month_ready, month_valid;
  logic result_ready;

  // The ready chain runs back from the output register through every stage.
  assign in_stall_o = !front_ready;

  cddn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .item_i  (in_item_i),
    .valid_o (front_valid),
    .ready_i (year_ready),
    .stage_o (front_stage)
  );

  cddn_year u_year (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (year_ready),
    .stage_i (front_stage),
    .valid_o (year_valid),
    .ready_i (month_ready),
    .stage_o (year_stage)
  );

  cddn_month u_month (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (year_valid),
    .ready_o (month_ready),
    .stage_i (year_stage),
    .valid_o (month_valid),
    .ready_i (result_ready),
    .stage_o (month_stage)
  );

  cddn_result u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (month_valid),
    .ready_o (result_ready),
    .stage_i (month_stage),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .item_o  (out_item_o)
  );

endmodule

// File: tb/sv/calendar_date_day_number_convert_check.sv
// Checker for the date / day number converter: predicts each result item and compares it.
`timescale 1ns / 1ps
module calendar_date_day_number_convert_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  cddn_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cddn_pkg::out_item_t out_item_i,
  output int unsigned         error_count_o,
  output int unsigned         pending_o
);

  cddn_pkg::out_item_t awaited_results[$];
  cddn_pkg::out_item_t oldest;
  int unsigned         fault_total = 0;

  // Days from 0001-01-01 through the end of year y.
  function automatic int unsigned days_through_year(input int unsigned y);
    return y * 365 + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic bit gregorian_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input bit lp);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return lp ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Days before month m in a year that counts February as 30 days.
  function automatic int unsigned days_ahead_of_month(input int unsigned m);
    return (m * 3057 - 3007) / 100;
  endfunction

  function automatic cddn_pkg::out_item_t expected_conversion(input cddn_pkg::in_item_t it);
    cddn_pkg::out_item_t r;
    int unsigned         d, m, yo, jn, y, mlen, doy, dn, t, mo;
    bit                  lp;
    r = '0;
    if (it.opcode == cddn_pkg::OP_TO_NUMBER) begin
      d    = it.in_day;
      m    = it.in_month;
      yo   = it.in_year_offset;
      lp   = gregorian_leap(yo + 1900);
      mlen = days_in_month(m, lp);
      r.out_day         = it.in_day;
      r.out_month       = it.in_month;
      r.out_year_offset = it.in_year_offset;
      r.leap_year       = lp;
      r.month_length    = 5'(mlen);
      if (d >= 1 && mlen != 0 && d <= mlen) begin
        doy = days_ahead_of_month(m);
        if (m > 2) doy -= lp ? 1 : 2;
        doy += d;
        dn = days_through_year(yo + 1899) + doy;
        r.out_day_number = 20'(dn);
        r.weekday        = 3'((dn - 1) % 7);
        r.day_of_year    = 9'(doy);
        r.valid_res      = 1'b1;
      end
    end else begin
      jn = it.in_day_number;
      r.out_day_number = it.in_day_number;
      // The estimate never overshoots, so the year only moves upward.
      y = jn * 400 / 146097;
      while (days_through_year(y) < jn) y++;
      if (y >= 1900 && y <= 2027) begin
        lp  = gregorian_leap(y);
        t   = jn - days_through_year(y - 1);
        doy = t;
        if (t > 59) begin
          t += 2;
          if (lp) t -= (t > 62) ? 1 : 2;
        end
        mo = (t * 100 + 3007) / 3057;
        r.out_day         = 5'(t - days_ahead_of_month(mo));
        r.out_month       = 4'(mo);
        r.out_year_offset = 7'(y - 1900);
        r.weekday         = 3'((jn - 1) % 7);
        r.day_of_year     = 9'(doy);
        r.leap_year       = lp;
        r.month_length    = 5'(days_in_month(mo, lp));
        r.valid_res       = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fault_total++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      pending_o     <= 0;
      error_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result item arrived with no item outstanding");
          fault_total++;
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("out_day_number", oldest.out_day_number, out_item_i.out_day_number);
          compare_field("out_day", oldest.out_day, out_item_i.out_day);
          compare_field("out_month", oldest.out_month, out_item_i.out_month);
          compare_field("out_year_offset", oldest.out_year_offset,
                        out_item_i.out_year_offset);
          compare_field("weekday", oldest.weekday, out_item_i.weekday);
          compare_field("day_of_year", oldest.day_of_year, out_item_i.day_of_year);
          compare_field("leap_year", oldest.leap_year, out_item_i.leap_year);
          compare_field("month_length", oldest.month_length, out_item_i.month_length);
          compare_field("valid_res", oldest.valid_res, out_item_i.valid_res);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(expected_conversion(in_item_i));
      end
      pending_o     <= awaited_results.size();
      error_count_o <= fault_total;
    end
  end

endmodule

// File: tb/sv/calendar_date_day_number_convert_test.sv
// Testbench top for the date / day number converter: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module calendar_date_day_number_convert_test;

  localparam int unsigned RANDOM_ITEMS   = 900;
  localparam int unsigned PHASES         = 3;
  // Cycles without any item moving on either channel before the run is abandoned.
  // The longest legal quiet stretch is a receiver or sender gap at 79 percent.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // The pipeline is six stages deep; allow some margin after the last result.
  localparam int unsigned DRAIN_CYCLES   = 16;

  // Day numbers of a few landmark dates around the leap day of a 400-year leap.
  localparam int unsigned DN_LEAP_DAY_2000 = 730179;  // 2000-02-29
  localparam int unsigned DN_MARCH_2000    = 730180;  // 2000-03-01
  localparam int unsigned DN_END_2000      = 730485;  // 2000-12-31

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  cddn_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cddn_pkg::out_item_t out_item;

  int unsigned error_count;
  int unsigned pending_count;

  // Chance in percent that the sender idles before an item, drawn again after each
  // idle cycle, and that the receiver stalls in a given cycle.
  int unsigned sender_gap_pct = 0;
  int unsigned stall_pct      = 0;
  int unsigned quiet_cycles   = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  calendar_date_day_number_convert dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  calendar_date_day_number_convert_check check_u (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .error_count_o (error_count),
    .pending_o     (pending_count)
  );

  // The receiver decides afresh every cycle whether to hold off the next result.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // A hang shows up as a long run of cycles in which no item moves at all.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("calendar_date_day_number_convert_test: errors");
      $finish;
    end
  end

  // Presents one item and returns at the edge where it is taken. When no gap is
  // drawn, valid simply stays high and only the payload changes, so valid never
  // gets two updates in one time step.
  task automatic offer_item(input cddn_pkg::in_item_t item);
    if ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_gap_pct);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending until every result item owed so far has come back. The first
  // edge is always waited out, since the count is registered.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // A date conversion item; the day number field is ignored and carries noise.
  function automatic cddn_pkg::in_item_t date_item(input int unsigned d,
                                                   input int unsigned m,
                                                   input int unsigned yo);
    cddn_pkg::in_item_t it;
    it.opcode         = cddn_pkg::OP_TO_NUMBER;
    it.in_day         = 5'(d);
    it.in_month       = 4'(m);
    it.in_year_offset = 7'(yo);
    it.in_day_number  = 20'($urandom);
    return it;
  endfunction

  // A day number conversion item; the date fields are ignored and carry noise.
  function automatic cddn_pkg::in_item_t number_item(input int unsigned jn);
    cddn_pkg::in_item_t it;
    it.opcode         = cddn_pkg::OP_TO_DATE;
    it.in_day         = 5'($urandom);
    it.in_month       = 4'($urandom);
    it.in_year_offset = 7'($urandom);
    it.in_day_number  = 20'(jn);
    return it;
  endfunction

  // Most items are well-formed dates or day numbers inside 1900..2027, so the
  // whole conversion is exercised; the rest are malformed dates, day numbers
  // close to either end of the range, and day numbers from the full field.
  function automatic cddn_pkg::in_item_t random_item();
    int unsigned pick;
    int unsigned day;
    int unsigned edge_base;
    pick      = $urandom_range(99);
    day       = ($urandom_range(9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    edge_base = ($urandom_range(1) == 0) ? int'(cddn_pkg::DN_FIRST_1900) :
                                           int'(cddn_pkg::DN_END_2027);
    if (pick < 40) begin
      return date_item(day, $urandom_range(1, 12), $urandom_range(127));
    end else if (pick < 50) begin
      return date_item($urandom_range(31), $urandom_range(15), $urandom_range(127));
    end else if (pick < 85) begin
      return number_item($urandom_range(int'(cddn_pkg::DN_FIRST_1900),
                                        int'(cddn_pkg::DN_END_2027)));
    end else if (pick < 92) begin
      return number_item(edge_base + $urandom_range(8) - 4);
    end else begin
      return number_item($urandom_range(20'hFFFFF));
    end
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    sender_gap_pct = 12;
    stall_pct      = 79;

    // Dates at both ends of the supported years and around February.
    offer_item(date_item(1, 1, 0));        // first day of 1900
    offer_item(date_item(31, 12, 127));    // last day of 2027
    offer_item(date_item(29, 2, 100));     // leap day of a 400-year leap
    offer_item(date_item(29, 2, 0));       // 1900 is a century, so no leap day
    offer_item(date_item(29, 2, 124));     // ordinary leap day
    offer_item(date_item(29, 2, 123));     // leap day in a common year
    offer_item(date_item(1, 3, 99));       // March in a common year
    offer_item(date_item(1, 3, 124));      // March in a leap year
    // Malformed dates: zero day, out-of-range months, day past the month end.
    offer_item(date_item(0, 6, 50));
    offer_item(date_item(15, 0, 50));
    offer_item(date_item(15, 13, 50));
    offer_item(date_item(31, 15, 127));
    offer_item(date_item(31, 4, 80));
    offer_item(date_item(0, 0, 0));
    // Day numbers: zero, year one, range edges, field maximum and 2000 landmarks.
    offer_item(number_item(0));
    offer_item(number_item(1));
    offer_item(number_item(int'(cddn_pkg::DN_END_1899)));
    offer_item(number_item(int'(cddn_pkg::DN_FIRST_1900)));
    offer_item(number_item(int'(cddn_pkg::DN_END_2027)));
    offer_item(number_item(int'(cddn_pkg::DN_END_2027) + 1));
    offer_item(number_item(20'hFFFFF));
    offer_item(number_item(DN_LEAP_DAY_2000));
    offer_item(number_item(DN_MARCH_2000));
    offer_item(number_item(DN_END_2000));
    hold_until_drained();

    // Three random phases: a slow receiver, then a slow sender, then full rate.
    for (phase = 0; phase < PHASES; phase++) begin
      sender_gap_pct = (phase == 0) ? 12 : (phase == 1) ? 79 : 0;
      stall_pct      = (phase == 0) ? 79 : (phase == 1) ? 12 : 0;
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        offer_item(random_item());
      end
      hold_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("calendar_date_day_number_convert_test: clean");
    end else begin
      $display("calendar_date_day_number_convert_test: errors");
    end
    $finish;
  end

endmodule
